[hdl/lbpm_pkg.sv]
// shared types and constants of the latency budget percentile monitor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lbpm_pkg;

  localparam int unsigned LAT_W       = 32;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned MEAN_W      = 40;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned STORED_W    = 11;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned DIVIDEND_W  = SUM_W + FRAC_W;
  localparam int unsigned DIVISOR_W   = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
  localparam int unsigned DEF_RING_DEPTH = 1024;

  localparam logic [LAT_W-1:0]    BUDGET_RST    = 32'd1000;
  localparam logic [STORED_W-1:0] RING_SIZE_RST = 11'd1024;

  // floor(99 * m / 100) as (m * RANK_MUL) >> RANK_SHIFT, with
  // RANK_MUL = 99 * ceil(2^32 / 100); exact for every fill count in range
  localparam int unsigned  RANK_SHIFT = 32;
  localparam logic [31:0]  RANK_MUL   = 32'd4252017627;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUDGET    = 2'd0,
    REG_RING_SIZE = 2'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_SELWAIT,
    ST_MDIV,
    ST_MWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             done;
    logic [LAT_W-1:0] value;
  } sel_rsp_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[hdl/lbpm_ram.sv]
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lbpm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/lbpm_div.sv]
// restoring divider, one quotient bit per cycle
// depends on lbpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbpm_div import lbpm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output div_rsp_t                   rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] acc_q, acc_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  den_q, den_d;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  assign shifted = {rem_q, acc_q[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIVIDEND_W);
      acc_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DIVISOR_W'(shifted - {1'b0, den_q}) : shifted[DIVISOR_W-1:0];
      acc_d = {acc_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = acc_q;

endmodule

`default_nettype wire

[hdl/lbpm_sel.sv]
// rank selection by value bisection, one ring entry compared per cycle
// depends on lbpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbpm_sel import lbpm_pkg::*; #(
  parameter int unsigned RING_DEPTH = DEF_RING_DEPTH,
  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int unsigned CW = $clog2(RING_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CW-1:0]    count_i,
  input  wire logic [CW-1:0]    rank_i,
  output logic      [AW-1:0]    raddr_o,
  input  wire logic [LAT_W-1:0] rdata_i,
  output sel_rsp_t              rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             vld_q, vld_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    le_q, le_d;
  logic [CW-1:0]    n_q, n_d;
  logic [CW-1:0]    k_q, k_d;
  logic [LAT_W-1:0] lo_q, lo_d;
  logic [LAT_W-1:0] hi_q, hi_d;
  logic [LAT_W-1:0] mid;
  logic [LAT_W-1:0] nlo, nhi;

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign nlo     = (le_q > k_q) ? lo_q : mid + 1'b1;
  assign nhi     = (le_q > k_q) ? mid : hi_q;
  assign raddr_o = idx_q[AW-1:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    vld_d  = 1'b0;
    idx_d  = idx_q;
    le_d   = le_q;
    n_d    = n_q;
    k_d    = k_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      le_d   = '0;
      n_d    = count_i;
      k_d    = rank_i;
      lo_d   = '0;
      hi_d   = '1;
    end else if (busy_q) begin
      if (idx_q != n_q) begin
        idx_d = idx_q + 1'b1;
        vld_d = 1'b1;
      end
      if (vld_q && (rdata_i <= mid)) begin
        le_d = le_q + 1'b1;
      end
      // pass over all entries finished: halve the value interval
      if ((idx_q == n_q) && !vld_q) begin
        lo_d  = nlo;
        hi_d  = nhi;
        idx_d = '0;
        le_d  = '0;
        if (nlo >= nhi) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      vld_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      vld_q  <= vld_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    le_q <= le_d;
    n_q  <= n_d;
    k_q  <= k_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = lo_q;

endmodule

`default_nettype wire

[hdl/latency_budget_percentile_monitor_unit.sv]
// latency budget monitor: check counters, sample ring, p99 and mean readout
// depends on lbpm_pkg, lbpm_ram, lbpm_div, lbpm_sel
//
// usage
// - input channel (in_valid_i / in_ready_o) carries command_i and elapsed_us_i;
//   check counts a call against the budget, record stores a sample into the
//   ring and the running sum, clear empties all statistics, code 3 only reports
// - every input transfer gives exactly one output transfer on
//   out_valid_o / out_ready_i with the state after the item took effect
// - config channel (cfg_valid_i / cfg_ready_o): index 0 budget, index 1 ring
//   size; a write to either clears all statistics, other indexes are ignored;
//   config is taken only while no item is in flight
// - per item with n stored samples: the p99 search makes 32 bisection passes
//   over the n stored samples, one ring entry per cycle through the single
//   ring read port, then the mean divide runs; with no samples the search is
//   skipped, and with no records the divide is skipped as well
// - one item at a time; the next item is accepted while the previous result
//   still waits in the output register, and a stalled receiver holds the
//   finished item in the done state until the output register frees up
// - reset: budget 1000, ring size 1024, all counters and the sum zero; the
//   ring needs no clearing pass since only slots below the fill count are read
`timescale 1ns / 1ps
`default_nettype none

module latency_budget_percentile_monitor_unit import lbpm_pkg::*; #(
  parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CMD_W-1:0]     command_i,
  input  wire logic [LAT_W-1:0]     elapsed_us_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      within_budget_o,
  output logic [CNT_W-1:0]          check_total_o,
  output logic [CNT_W-1:0]          exceeded_total_o,
  output logic [STORED_W-1:0]       stored_samples_o,
  output logic [LAT_W-1:0]          p99_latency_o,
  output logic [MEAN_W-1:0]         mean_latency_q8_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LAT_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned KP_W = CW + RANK_SHIFT;

  state_e state_q, state_d;

  // configuration
  logic [LAT_W-1:0]    budget_q, budget_d;
  logic [STORED_W-1:0] ring_size_q, ring_size_d;

  // statistics
  logic [AW-1:0]    slot_q, slot_d;
  logic [CW-1:0]    nvalid_q, nvalid_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] ncomp_q, ncomp_d;
  logic [CNT_W-1:0] nchk_q, nchk_d;
  logic [CNT_W-1:0] nover_q, nover_d;

  // per item results
  logic              within_q, within_d;
  logic [LAT_W-1:0]  p99_q, p99_d;
  logic [MEAN_W-1:0] mean_q, mean_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                o_within_q, o_within_d;
  logic [CNT_W-1:0]    o_chk_q, o_chk_d;
  logic [CNT_W-1:0]    o_over_q, o_over_d;
  logic [STORED_W-1:0] o_stored_q, o_stored_d;
  logic [LAT_W-1:0]    o_p99_q, o_p99_d;
  logic [MEAN_W-1:0]   o_mean_q, o_mean_d;

  logic                  in_xfer, cfg_xfer;
  logic [CW-1:0]         size_use;
  logic [AW-1:0]         slot_eff;
  logic [31:0]           slot_inc;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [AW-1:0]         sel_addr;
  logic [LAT_W-1:0]      ram_rdata;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  div_rsp_t              div_rsp;
  logic                  sel_start;
  sel_rsp_t              sel_rsp;
  logic [CW-1:0]         nvalid_m1;
  logic [KP_W-1:0]       rank_prod;
  logic [CW-1:0]         rank_k;

  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // ring size in use, capped at the physical depth
  assign size_use = ({21'b0, ring_size_q} > 32'(RING_DEPTH)) ? CW'(RING_DEPTH)
                                                              : CW'(ring_size_q);
  assign slot_eff = (32'(slot_q) >= 32'(size_use)) ? '0 : slot_q;
  assign slot_inc = 32'(slot_eff) + 32'd1;

  assign ram_we   = in_xfer && (cmd_e'(command_i) == CMD_RECORD) && (size_use != '0);
  assign ram_addr = ram_we ? slot_eff : sel_addr;

  // p99 rank floor(99 * (n - 1) / 100) by reciprocal multiplication
  assign nvalid_m1 = nvalid_q - 1'b1;
  assign rank_prod = KP_W'(nvalid_m1) * KP_W'(RANK_MUL);
  assign rank_k    = rank_prod[KP_W-1:RANK_SHIFT];

  // statistics update on transfers
  always_comb begin
    budget_d    = budget_q;
    ring_size_d = ring_size_q;
    slot_d      = slot_q;
    nvalid_d    = nvalid_q;
    sum_d       = sum_q;
    ncomp_d     = ncomp_q;
    nchk_d      = nchk_q;
    nover_d     = nover_q;
    within_d    = within_q;
    if (cfg_xfer) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BUDGET: begin
          budget_d = cfg_data_i;
          slot_d   = '0;
          nvalid_d = '0;
          sum_d    = '0;
          ncomp_d  = '0;
          nchk_d   = '0;
          nover_d  = '0;
        end
        REG_RING_SIZE: begin
          ring_size_d = cfg_data_i[STORED_W-1:0];
          slot_d      = '0;
          nvalid_d    = '0;
          sum_d       = '0;
          ncomp_d     = '0;
          nchk_d      = '0;
          nover_d     = '0;
        end
        default: ;
      endcase
    end else if (in_xfer) begin
      within_d = 1'b0;
      case (cmd_e'(command_i))
        CMD_CHECK: begin
          if (nchk_q != '1) nchk_d = nchk_q + 1'b1;
          if (elapsed_us_i >= budget_q) begin
            if (nover_q != '1) nover_d = nover_q + 1'b1;
          end else begin
            within_d = 1'b1;
          end
        end
        CMD_RECORD: begin
          if (size_use != '0) begin
            slot_d = (slot_inc >= 32'(size_use)) ? '0 : AW'(slot_inc);
            if (nvalid_q < size_use) nvalid_d = nvalid_q + 1'b1;
          end
          // sum and count freeze once the count saturates
          if (ncomp_q != '1) begin
            sum_d   = sum_q + SUM_W'(elapsed_us_i);
            ncomp_d = ncomp_q + 1'b1;
          end
        end
        CMD_CLEAR: begin
          slot_d   = '0;
          nvalid_d = '0;
          sum_d    = '0;
          ncomp_d  = '0;
          nchk_d   = '0;
          nover_d  = '0;
        end
        default: ;
      endcase
    end
  end

  // sequencer: bisection for p99, mean divide, hand to output register
  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = {sum_q, FRAC_W'(0)};
    div_divisor  = ncomp_q;
    sel_start    = 1'b0;
    p99_d        = p99_q;
    mean_d       = mean_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    o_within_d   = o_within_q;
    o_chk_d      = o_chk_q;
    o_over_d     = o_over_q;
    o_stored_d   = o_stored_q;
    o_p99_d      = o_p99_q;
    o_mean_d     = o_mean_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_RANK;
      end
      ST_RANK: begin
        if (nvalid_q == '0) begin
          p99_d   = '0;
          state_d = ST_MDIV;
        end else begin
          sel_start = 1'b1;
          state_d   = ST_SELWAIT;
        end
      end
      ST_SELWAIT: begin
        if (sel_rsp.done) begin
          p99_d   = sel_rsp.value;
          state_d = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (ncomp_q == '0) begin
          mean_d  = '0;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_MWAIT;
        end
      end
      ST_MWAIT: begin
        if (div_rsp.done) begin
          mean_d  = div_rsp.quotient[MEAN_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_within_d  = within_q;
          o_chk_d     = nchk_q;
          o_over_d    = nover_q;
          o_stored_d  = STORED_W'(nvalid_q);
          o_p99_d     = p99_q;
          o_mean_d    = mean_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      budget_q    <= BUDGET_RST;
      ring_size_q <= RING_SIZE_RST;
      slot_q      <= '0;
      nvalid_q    <= '0;
      sum_q       <= '0;
      ncomp_q     <= '0;
      nchk_q      <= '0;
      nover_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      budget_q    <= budget_d;
      ring_size_q <= ring_size_d;
      slot_q      <= slot_d;
      nvalid_q    <= nvalid_d;
      sum_q       <= sum_d;
      ncomp_q     <= ncomp_d;
      nchk_q      <= nchk_d;
      nover_q     <= nover_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    within_q   <= within_d;
    p99_q      <= p99_d;
    mean_q     <= mean_d;
    o_within_q <= o_within_d;
    o_chk_q    <= o_chk_d;
    o_over_q   <= o_over_d;
    o_stored_q <= o_stored_d;
    o_p99_q    <= o_p99_d;
    o_mean_q   <= o_mean_d;
  end

  lbpm_ram #(
    .WIDTH (LAT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (elapsed_us_i),
    .rdata_o (ram_rdata)
  );

  lbpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rsp_o      (div_rsp)
  );

  lbpm_sel #(
    .RING_DEPTH (RING_DEPTH)
  ) u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sel_start),
    .count_i (nvalid_q),
    .rank_i  (rank_k),
    .raddr_o (sel_addr),
    .rdata_i (ram_rdata),
    .rsp_o   (sel_rsp)
  );

  assign out_valid_o       = out_valid_q;
  assign within_budget_o   = o_within_q;
  assign check_total_o     = o_chk_q;
  assign exceeded_total_o  = o_over_q;
  assign stored_samples_o  = o_stored_q;
  assign p99_latency_o     = o_p99_q;
  assign mean_latency_q8_o = o_mean_q;

endmodule

`default_nettype wire

[tb/sv/latency_budget_percentile_monitor_unit_tb.sv]
// self-checking testbench for the latency budget percentile monitor
// depends on lbpm_pkg and latency_budget_percentile_monitor_unit
`timescale 1ns / 1ps

module latency_budget_percentile_monitor_unit_tb;
  import lbpm_pkg::*;

  // idle profiles, sender and receiver side
  localparam int unsigned IDLE_NONE = 0;
  localparam int unsigned IDLE_SEND = 1;
  localparam int unsigned IDLE_RECV = 2;
  localparam int unsigned IDLE_BOTH = 3;
  // register indexes the block ignores
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned DEPTH = DEF_RING_DEPTH;
  // idle cycles without any transfer before the run is abandoned
  localparam int unsigned STALL_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic                in_budget;
    logic [CNT_W-1:0]    checks;
    logic [CNT_W-1:0]    over;
    logic [STORED_W-1:0] stored;
    logic [LAT_W-1:0]    p99;
    logic [MEAN_W-1:0]   mean;
  } report_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     command_i;
  logic [LAT_W-1:0]     elapsed_us_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 within_budget_o;
  logic [CNT_W-1:0]     check_total_o;
  logic [CNT_W-1:0]     exceeded_total_o;
  logic [STORED_W-1:0]  stored_samples_o;
  logic [LAT_W-1:0]     p99_latency_o;
  logic [MEAN_W-1:0]    mean_latency_q8_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [LAT_W-1:0]     cfg_data_i;

  latency_budget_percentile_monitor_unit u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .command_i, .elapsed_us_i,
    .out_valid_o, .out_ready_i,
    .within_budget_o, .check_total_o, .exceeded_total_o,
    .stored_samples_o, .p99_latency_o, .mean_latency_q8_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // shadow copy of the monitor state
  logic [LAT_W-1:0]    sh_budget;
  logic [STORED_W-1:0] sh_ring_size;
  logic [LAT_W-1:0]    sh_ring [DEPTH];
  int unsigned         sh_slot;
  int unsigned         sh_fill;
  logic [SUM_W-1:0]    sh_sum;
  logic [CNT_W-1:0]    sh_completions;
  logic [CNT_W-1:0]    sh_checks;
  logic [CNT_W-1:0]    sh_over;

  report_t     pending_reports [$];
  int unsigned idle_mode;
  int unsigned mismatches;
  int unsigned reports_seen;
  int unsigned items_sent;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_shadow();
    sh_slot = 0;
    sh_fill = 0;
    sh_sum = '0;
    sh_completions = '0;
    sh_checks = '0;
    sh_over = '0;
  endfunction

  // idle share in percent for the active profile
  function automatic int unsigned idle_pct();
    return (idle_mode == IDLE_BOTH) ? 31 : 71;
  endfunction

  // k-th smallest stored sample, counting ties
  function automatic logic [LAT_W-1:0] rank_value(int unsigned k);
    int unsigned lt;
    int unsigned le;
    for (int unsigned i = 0; i < sh_fill; i++) begin
      lt = 0;
      le = 0;
      for (int unsigned j = 0; j < sh_fill; j++) begin
        if (sh_ring[j] < sh_ring[i]) lt++;
        if (sh_ring[j] <= sh_ring[i]) le++;
      end
      if (lt <= k && k < le) return sh_ring[i];
    end
    return '0;
  endfunction

  // apply one item to the shadow state and form the report it gives
  function automatic report_t monitor_report(cmd_e cmd, logic [LAT_W-1:0] us);
    report_t     r;
    int unsigned size;
    logic [DIVIDEND_W-1:0] scaled;
    r = '0;
    size = (sh_ring_size > DEPTH) ? DEPTH : sh_ring_size;
    case (cmd)
      CMD_CHECK: begin
        if (sh_checks != '1) sh_checks++;
        if (us >= sh_budget) begin
          if (sh_over != '1) sh_over++;
        end else begin
          r.in_budget = 1'b1;
        end
      end
      CMD_RECORD: begin
        if (size != 0) begin
          if (sh_slot >= size) sh_slot = 0;
          sh_ring[sh_slot] = us;
          sh_slot++;
          if (sh_slot >= size) sh_slot = 0;
          if (sh_fill < size) sh_fill++;
        end
        // frozen once the completion count saturates
        if (sh_completions != '1) begin
          sh_sum += us;
          sh_completions++;
        end
      end
      CMD_CLEAR: clear_shadow();
      default: ;
    endcase
    r.checks = sh_checks;
    r.over = sh_over;
    r.stored = sh_fill[STORED_W-1:0];
    if (sh_fill != 0) r.p99 = rank_value((99 * (sh_fill - 1)) / 100);
    if (sh_completions != 0) begin
      scaled = {sh_sum, {FRAC_W{1'b0}}} / sh_completions;
      r.mean = scaled[MEAN_W-1:0];
    end
    return r;
  endfunction

  // one input transfer, with sender idling per profile
  task automatic send_item(cmd_e cmd, logic [LAT_W-1:0] us);
    @(negedge clk_i);
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < idle_pct()) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    command_i = cmd;
    elapsed_us_i = us;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_reports.push_back(monitor_report(cmd, us));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // register write, only with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LAT_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_BUDGET) begin
      sh_budget = data;
      clear_shadow();
    end else if (idx == REG_RING_SIZE) begin
      sh_ring_size = data[STORED_W-1:0];
      clear_shadow();
    end
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // random latency, often close to the budget so both outcomes show up
  function automatic logic [LAT_W-1:0] pick_latency();
    case ($urandom_range(3))
      0: return $urandom();
      1: return sh_budget + $urandom_range(2) - 1;
      2: return $urandom_range(2000);
      default: return LAT_W'($urandom_range(511) << $urandom_range(24));
    endcase
  endfunction

  task automatic random_items(int unsigned count);
    int unsigned pick;
    cmd_e        cmd;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) cmd = CMD_CHECK;
      else if (pick < 88) cmd = CMD_RECORD;
      else if (pick < 93) cmd = CMD_CLEAR;
      else cmd = CMD_NONE;
      send_item(cmd, pick_latency());
    end
  endtask

  // defaults after reset, field extremes and every command
  task automatic test_directed_defaults();
    idle_mode = IDLE_NONE;
    send_item(CMD_CHECK, 32'd999);
    send_item(CMD_CHECK, 32'd1000);
    send_item(CMD_CHECK, 32'd0);
    send_item(CMD_CHECK, '1);
    send_item(CMD_RECORD, '1);
    send_item(CMD_RECORD, 32'd0);
    send_item(CMD_RECORD, '1);
    send_item(CMD_RECORD, 32'h5555_5555);
    send_item(CMD_RECORD, 32'hAAAA_AAAA);
    send_item(CMD_NONE, 32'h1234_5678);
    send_item(CMD_CLEAR, '1);
    send_item(CMD_RECORD, 32'd7);
  endtask

  // register extremes, oversized and zero ring, ignored indexes
  task automatic test_register_corners();
    write_reg(REG_BUDGET, '0);
    send_item(CMD_CHECK, '0);
    write_reg(REG_BUDGET, '1);
    send_item(CMD_CHECK, 32'hFFFF_FFFE);
    send_item(CMD_CHECK, '1);
    write_reg(REG_RING_SIZE, 32'd0);
    send_item(CMD_RECORD, 32'd300);
    send_item(CMD_RECORD, 32'd301);
    write_reg(REG_RING_SIZE, 32'd2047);
    send_item(CMD_RECORD, 32'd42);
    write_reg(REG_RING_SIZE, 32'd1);
    send_item(CMD_RECORD, 32'd9);
    send_item(CMD_RECORD, 32'd4);
    // ignored writes keep the stats
    write_reg(REG_SPARE_A, 32'd5);
    write_reg(REG_SPARE_B, '1);
    send_item(CMD_CHECK, 32'd3);
  endtask

  // random traffic over several ring sizes and idle profiles
  task automatic test_random_traffic();
    int unsigned sizes [4] = '{3, 7, 16, 64};
    for (int unsigned p = 0; p < 4; p++) begin
      idle_mode = p;
      write_reg(REG_BUDGET, (p == 0) ? 32'd1000 : $urandom_range(3000));
      write_reg(REG_RING_SIZE, sizes[p]);
      random_items(25);
    end
    // full ring size, fewer items since each pass scales with the fill
    idle_mode = IDLE_BOTH;
    write_reg(REG_RING_SIZE, DEPTH);
    random_items(20);
  endtask

  // receiver stalls per profile
  always @(negedge clk_i) begin
    if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
      out_ready_i = ($urandom_range(99) >= idle_pct());
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // compare each output transfer with the oldest expected report
  always @(posedge clk_i) begin
    report_t want;
    report_t got;
    if (out_valid_o && out_ready_i) begin
      got = '{within_budget_o, check_total_o, exceeded_total_o,
              stored_samples_o, p99_latency_o, mean_latency_q8_o};
      reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report transfer: %p", got);
      end else begin
        want = pending_reports.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("report mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("latency_budget_percentile_monitor_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_CHECK;
    elapsed_us_i = '0;
    out_ready_i = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_BUDGET;
    cfg_data_i = '0;
    idle_mode = IDLE_NONE;
    mismatches = 0;
    reports_seen = 0;
    items_sent = 0;
    cfg_writes = 0;
    quiet_cycles = 0;
    sh_budget = BUDGET_RST;
    sh_ring_size = RING_SIZE_RST;
    clear_shadow();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_defaults();
    test_register_corners();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d items and %0d register writes, %0d reports checked",
             items_sent, cfg_writes, reports_seen);
    $display("ring sizes 0 to oversized, budget extremes, all four idle profiles");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("latency_budget_percentile_monitor_unit_tb OK");
    end else begin
      $display("latency_budget_percentile_monitor_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lbpm_pkg.sv
hdl/lbpm_ram.sv
hdl/lbpm_div.sv
hdl/lbpm_sel.sv
hdl/latency_budget_percentile_monitor_unit.sv
tb/sv/latency_budget_percentile_monitor_unit_tb.sv
